FILE: rtl/rc4sc_pkg.sv
// Shared types, constants and state encoding for the RC4 stream cipher block.
`default_nettype none
package rc4sc_pkg;

   localparam int KEY_MAX_DEF = 256;
   localparam int LEN_W       = 9;
   localparam int BYTE_W      = 8;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_NOKEY = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] value;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] result_byte;
      logic              status;
   } rsp_type;

   typedef enum logic {
      KIND_KEY,
      KIND_DATA
   } kind_type;

   // Classified beat handed from the front queue to the engine.
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] value;
      logic              last;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RDN,
      ST_KS_RDA,
      ST_KS_WRN,
      ST_KS_WRA,
      ST_D_RDJ,
      ST_D_WRI,
      ST_D_WRJ,
      ST_D_RDT,
      ST_D_OUT
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/rc4_stream_cipher_top.sv
// Top level of the RC4 stream cipher: input queue, engine and result register.
`default_nettype none
// A key beat is stored while the key memory has room; the beat marked last then runs the
// key schedule, which loads the identity permutation and then makes 256 swap steps. A data
// byte runs the keystream steps with a key held and is returned unchanged with a no-key
// status without one; a data byte marked last with a key held is followed by the same
// schedule. The swaps are serialized through the permutation memory, which has one write
// port and one registered read port. A two-beat input queue keeps taking beats while the
// engine works, and a one-beat result register lets the engine finish while a result waits to be popped.
module rc4_stream_cipher_top #(
   parameter int KEY_MAX = rc4sc_pkg::KEY_MAX_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire rc4sc_pkg::req_type req_item,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output rc4sc_pkg::rsp_type      rsp_item
);
   import rc4sc_pkg::*;

   job_type job;
   logic    job_valid, job_ready;
   logic    res_valid, res_free;
   rsp_type res;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff;

   rc4sc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .item      (req_item),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   rc4sc_engine #(.KEY_MAX(KEY_MAX)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .res_free  (res_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register: free when empty or being popped this cycle.
   assign res_free   = !rsp_vld_ff || rsp_pop;
   assign rsp_vld_in = res_valid || (rsp_vld_ff && !rsp_pop);
   assign rsp_empty  = !rsp_vld_ff;
   assign rsp_item   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/rc4sc_front.sv
// Input queue that accepts beats, tags them as key or data and hands them to the engine.
`default_nettype none
module rc4sc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire rc4sc_pkg::req_type item,
   output logic                   job_valid,
   input  wire logic              job_ready,
   output rc4sc_pkg::job_type     job
);
   import rc4sc_pkg::*;

   req_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   req_type    head;

   assign full      = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = job_valid && job_ready;
   assign head      = q_ff[rd_ptr_ff];

   // Classify the oldest beat by its opcode.
   always_comb begin
      job.kind  = (head.opcode == OP_DATA) ? KIND_DATA : KIND_KEY;
      job.value = head.value;
      job.last  = head.last;
   end

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/rc4sc_engine.sv
// Back end: key memory, permutation memory, key schedule and keystream sequencer.
`default_nettype none
module rc4sc_engine #(
   parameter int KEY_MAX = rc4sc_pkg::KEY_MAX_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire rc4sc_pkg::job_type job,
   input  wire logic              res_free,
   output logic                   res_valid,
   output rc4sc_pkg::rsp_type     res
);
   import rc4sc_pkg::*;

   localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

   logic [BYTE_W-1:0] smem [256];
   logic [BYTE_W-1:0] kmem [KEY_MAX];
   logic [BYTE_W-1:0] s_rd_ff, k_rd_ff;

   state_type   st_ff, st_in;
   logic [7:0]  n_ff, n_in;
   logic [LEN_W-1:0] kpos_ff, kpos_in, len_ff, len_in, len_eff, kpos_inc;
   logic [7:0]  acc_ff, acc_in, i_ff, i_in, j_ff, j_in, si_ff, si_in, t_ff, t_in;
   logic        keyok_ff, keyok_in;
   logic [7:0]  val_ff, val_in;
   logic        last_ff, last_in;

   logic        s_we, k_we;
   logic [7:0]  s_wa, s_wd, s_ra;
   logic [KEY_AW-1:0] k_wa, k_ra;
   logic        accept, store;

   assign accept   = job_valid && job_ready;
   assign len_eff  = keyok_ff ? '0 : len_ff;
   assign store    = (len_eff < LEN_W'(KEY_MAX));
   assign kpos_inc = kpos_ff + LEN_W'(1);

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (job.kind == KIND_KEY) begin
                  st_in = job.last ? ST_INIT : ST_IDLE;
               end else if (keyok_ff) begin
                  st_in = ST_D_RDJ;
               end
            end
         end
         ST_INIT:   st_in = (n_ff == 8'hFF) ? ST_KS_RDN : ST_INIT;
         ST_KS_RDN: st_in = ST_KS_RDA;
         ST_KS_RDA: st_in = ST_KS_WRN;
         ST_KS_WRN: st_in = ST_KS_WRA;
         ST_KS_WRA: st_in = (n_ff == 8'hFF) ? ST_IDLE : ST_KS_RDN;
         ST_D_RDJ:  st_in = ST_D_WRI;
         ST_D_WRI:  st_in = ST_D_WRJ;
         ST_D_WRJ:  st_in = ST_D_RDT;
         ST_D_RDT:  st_in = ST_D_OUT;
         ST_D_OUT: begin
            if (res_free) begin
               st_in = last_ff ? ST_INIT : ST_IDLE;
            end
         end
         default:   st_in = ST_IDLE;
      endcase
   end

   // Memory controls, result and datapath next values.
   always_comb begin
      job_ready = 1'b0;
      res_valid = 1'b0;
      res.result_byte = val_ff ^ s_rd_ff;
      res.status      = STATUS_OK;
      s_we = 1'b0; s_wa = n_ff; s_wd = n_ff; s_ra = n_ff;
      k_we = 1'b0; k_wa = len_eff[KEY_AW-1:0]; k_ra = kpos_ff[KEY_AW-1:0];
      n_in = n_ff; kpos_in = kpos_ff; len_in = len_ff; acc_in = acc_ff;
      i_in = i_ff; j_in = j_ff; si_in = si_ff; t_in = t_ff;
      keyok_in = keyok_ff; val_in = val_ff; last_in = last_ff;
      unique case (st_ff)
         ST_IDLE: begin
            job_ready = res_free;
            if (accept) begin
               val_in  = job.value;
               last_in = job.last;
               n_in    = 8'd0;
               if (job.kind == KIND_KEY) begin
                  // A key beat after a complete key starts a new key.
                  keyok_in = 1'b0;
                  k_we     = store;
                  len_in   = len_eff + LEN_W'(store);
               end else if (keyok_ff) begin
                  i_in = i_ff + 8'd1;
                  s_ra = i_in;
               end else begin
                  res_valid       = 1'b1;
                  res.result_byte = job.value;
                  res.status      = STATUS_NOKEY;
               end
            end
         end
         ST_INIT: begin
            s_we = 1'b1;
            n_in = n_ff + 8'd1;
            kpos_in = '0;
            acc_in  = 8'd0;
         end
         ST_KS_RDN: begin
            s_ra = n_ff;
         end
         ST_KS_RDA: begin
            acc_in = acc_ff + k_rd_ff + s_rd_ff;
            si_in  = s_rd_ff;
            s_ra   = acc_in;
         end
         ST_KS_WRN: begin
            s_we = 1'b1; s_wa = n_ff; s_wd = s_rd_ff;
         end
         ST_KS_WRA: begin
            s_we = 1'b1; s_wa = acc_ff; s_wd = si_ff;
            n_in    = n_ff + 8'd1;
            kpos_in = (kpos_inc >= len_ff) ? '0 : kpos_inc;
            if (n_ff == 8'hFF) begin
               keyok_in = 1'b1;
               i_in = 8'd0;
               j_in = 8'd0;
            end
         end
         ST_D_RDJ: begin
            si_in = s_rd_ff;
            j_in  = j_ff + s_rd_ff;
            s_ra  = j_in;
         end
         ST_D_WRI: begin
            s_we = 1'b1; s_wa = i_ff; s_wd = s_rd_ff;
            t_in = si_ff + s_rd_ff;
         end
         ST_D_WRJ: begin
            s_we = 1'b1; s_wa = j_ff; s_wd = si_ff;
         end
         ST_D_RDT: begin
            s_ra = t_ff;
         end
         ST_D_OUT: begin
            // Keep the address so the keystream byte stays on the read port.
            s_ra      = t_ff;
            res_valid = res_free;
            n_in      = 8'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         len_ff   <= '0;
         keyok_ff <= 1'b0;
         i_ff     <= 8'd0;
         j_ff     <= 8'd0;
      end else begin
         st_ff    <= st_in;
         len_ff   <= len_in;
         keyok_ff <= keyok_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      kpos_ff <= kpos_in;
      acc_ff  <= acc_in;
      si_ff   <= si_in;
      t_ff    <= t_in;
      val_ff  <= val_in;
      last_ff <= last_in;
   end

   // Permutation memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (s_we) begin
         smem[s_wa] <= s_wd;
      end
      s_rd_ff <= smem[s_ra];
   end

   // Key memory.
   always_ff @(posedge clock) begin
      if (k_we) begin
         kmem[k_wa] <= val_in;
      end
      k_rd_ff <= kmem[k_ra];
   end

endmodule
`default_nettype wire

FILE: rtl/rc4sc_checker.sv
// Port-level checker for the RC4 stream cipher top level and its bind.
`default_nettype none
module rc4sc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire rc4sc_pkg::rsp_type rsp_item
);
   import rc4sc_pkg::*;

   // Reset leaves the result register empty and the input queue not full.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A waiting result beat holds until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("waiting result beat changed");

   // A result cannot appear in the cycle right after reset.
   a_no_early_rsp: assert property (@(posedge clock)
      $fell(rsp_empty) |-> !$past(reset))
      else $error("result beat right after reset");

endmodule

bind rc4_stream_cipher_top rc4sc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);
`default_nettype wire
